### rtl/stcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds to calendar date: shared definitions
// Widths, calendar constants, state types, inter-module structs and the
// month-length table used by the date conversion unit.
// ----------------------------------------------------------------------------
package stcd_pkg;

    // Field widths.
    localparam int unsigned EPOCH_W = 32;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned WDAY_W  = 3;

    // Serial divider sizing: dividend shifts out MSB first, one bit per cycle.
    localparam int unsigned DIV_W = EPOCH_W;
    localparam int unsigned DVS_W = 17;
    localparam int unsigned CNT_W = 6;

    // Intermediate widths.
    localparam int unsigned DAYS_W = 16;
    localparam int unsigned SOD_W  = 17;
    localparam int unsigned MOD_W  = 11;
    localparam int unsigned BLK_W  = 6;
    localparam int unsigned DOY_W  = 11;

    // Calendar constants.
    localparam logic [EPOCH_W-1:0] MAX_EPOCH          = 32'd4102444799;
    localparam logic [DVS_W-1:0]   SEC_PER_DAY        = 17'd86400;
    localparam logic [DVS_W-1:0]   SIXTY              = 17'd60;
    localparam logic [DVS_W-1:0]   DAYS_PER_BLOCK     = 17'd1461;
    localparam logic [DAYS_W-1:0]  DAYS_BASE_TO_EPOCH = 16'd731;
    localparam logic [YEAR_W-1:0]  BASE_YEAR          = 12'd1968;
    localparam logic [DOY_W-1:0]   DAYS_LEAP_YEAR     = 11'd366;
    localparam logic [DOY_W-1:0]   DAYS_COMMON_YEAR   = 11'd365;
    localparam logic [2:0]         WEEK_LEN           = 3'd7;
    localparam logic [1:0]         LAST_YEAR_IN_BLOCK = 2'd3;
    localparam logic [MONTH_W-1:0] LAST_MONTH         = 4'd11;

    // Divider step counts for each phase.
    localparam logic [CNT_W-1:0] NBITS_DAY  = 6'd32;
    localparam logic [CNT_W-1:0] NBITS_YEAR = 6'd16;
    localparam logic [CNT_W-1:0] NBITS_MIN  = 6'd17;
    localparam logic [CNT_W-1:0] NBITS_HOUR = 6'd11;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_DAY,
        S_DIV_YEAR,
        S_DIV_MIN,
        S_DIV_HOUR,
        S_EMIT
    } t_seq_state;

    // Year and month walker states.
    typedef enum logic [1:0] {
        W_IDLE,
        W_YEAR,
        W_MONTH,
        W_DONE
    } t_walk_state;

    // Command to the serial divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [CNT_W-1:0] nbits;
    } t_div_cmd;

    // Status from the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
        logic bit_in;
    } t_div_stat;

    // Result of the year and month walker.
    typedef struct packed {
        logic               done;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_walk_res;

    // Length of a zero-based month; February depends on the leap flag.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1:                       len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### rtl/stcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds to calendar date: channel interfaces
// Valid/ready channels for the input word (epoch seconds) and the output
// word (calendar date and time of day).
// ----------------------------------------------------------------------------
interface stcd_in_if;
    logic                            valid;
    logic                            ready;
    logic [stcd_pkg::EPOCH_W-1:0]    epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface stcd_out_if;
    logic                            valid;
    logic                            ready;
    logic [stcd_pkg::YEAR_W-1:0]     year;
    logic [stcd_pkg::MONTH_W-1:0]    month;
    logic [stcd_pkg::DAY_W-1:0]      day_of_month;
    logic [stcd_pkg::HOUR_W-1:0]     hour;
    logic [stcd_pkg::MIN_W-1:0]      minute;
    logic [stcd_pkg::SEC_W-1:0]      second;
    logic [stcd_pkg::WDAY_W-1:0]     weekday;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, output weekday,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, input weekday,
                    output ready);
endinterface

### rtl/seconds_to_calendar_date_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds to calendar date conversion unit
// The shared bit-serial divider runs 32 + 16 + 17 + 11 steps (day, four-year
// block, minute, hour), each phase closing with its completion flag, and the
// emit state then registers the output word. A new word is accepted only
// while the unit is idle; a stalled output word holds the unit in its emit
// state. Reset is synchronous and active low; it idles the sequencer and
// drops the output valid flag.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stcd_in_if.sink     i_in,
    stcd_out_if.source  o_out
);

    stcd_pkg::t_seq_state r_state, n_state;

    stcd_pkg::t_div_cmd  w_cmd;
    stcd_pkg::t_div_stat w_stat;
    logic [stcd_pkg::DIV_W-1:0] w_quo;
    logic [stcd_pkg::DVS_W-1:0] w_rem;
    stcd_pkg::t_walk_res w_walk;
    logic                w_walk_start;

    logic                           w_accept;
    logic                           w_emit;
    logic [stcd_pkg::EPOCH_W-1:0]   w_sat;
    logic [stcd_pkg::DAYS_W-1:0]    w_rdays;
    logic [3:0]                     w_wk_x;
    logic [2:0]                     n_wk;

    logic [stcd_pkg::SOD_W-1:0]     r_sod;
    logic [stcd_pkg::SEC_W-1:0]     r_sec;
    logic [stcd_pkg::MIN_W-1:0]     r_min;
    logic [stcd_pkg::HOUR_W-1:0]    r_hour;
    logic [2:0]                     r_wk;

    logic                           r_out_valid;
    logic [stcd_pkg::YEAR_W-1:0]    r_out_year;
    logic [stcd_pkg::MONTH_W-1:0]   r_out_month;
    logic [stcd_pkg::DAY_W-1:0]     r_out_day;
    logic [stcd_pkg::HOUR_W-1:0]    r_out_hour;
    logic [stcd_pkg::MIN_W-1:0]     r_out_min;
    logic [stcd_pkg::SEC_W-1:0]     r_out_sec;
    logic [stcd_pkg::WDAY_W-1:0]    r_out_wday;

    // Shared bit-serial divider.
    stcd_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // Year and month walker; runs alongside the minute and hour divisions.
    stcd_datewalk u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_walk_start),
        .i_blocks       (w_quo[stcd_pkg::BLK_W-1:0]),
        .i_day_in_block (w_rem[stcd_pkg::DOY_W-1:0]),
        .o_res          (w_walk)
    );

    // Handshake terms, input saturation and the day count rebased to 1968.
    always_comb begin
        w_accept = i_in.valid && (r_state == stcd_pkg::S_IDLE);
        w_emit   = (r_state == stcd_pkg::S_EMIT) && w_walk.done
                   && (!r_out_valid || o_out.ready);
        w_sat    = (i_in.epoch_seconds > stcd_pkg::MAX_EPOCH) ? stcd_pkg::MAX_EPOCH
                                                               : i_in.epoch_seconds;
        w_rdays  = w_quo[stcd_pkg::DAYS_W-1:0] + stcd_pkg::DAYS_BASE_TO_EPOCH;
    end

    // Weekday: the rebased day count is congruent to days + 3 modulo 7, so its
    // residue is folded in MSB first as the bits leave the divider.
    always_comb begin
        w_wk_x = {r_wk, w_stat.bit_in};
        n_wk   = (w_wk_x >= {1'b0, stcd_pkg::WEEK_LEN})
                 ? 3'(w_wk_x - {1'b0, stcd_pkg::WEEK_LEN}) : w_wk_x[2:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stcd_pkg::S_IDLE:     if (w_accept) n_state = stcd_pkg::S_DIV_DAY;
            stcd_pkg::S_DIV_DAY:  if (w_stat.done) n_state = stcd_pkg::S_DIV_YEAR;
            stcd_pkg::S_DIV_YEAR: if (w_stat.done) n_state = stcd_pkg::S_DIV_MIN;
            stcd_pkg::S_DIV_MIN:  if (w_stat.done) n_state = stcd_pkg::S_DIV_HOUR;
            stcd_pkg::S_DIV_HOUR: if (w_stat.done) n_state = stcd_pkg::S_EMIT;
            stcd_pkg::S_EMIT:     if (w_emit) n_state = stcd_pkg::S_IDLE;
            default:              n_state = stcd_pkg::S_IDLE;
        endcase
    end

    // Divider commands and walker start for each phase.
    always_comb begin
        w_cmd        = '0;
        w_walk_start = 1'b0;
        unique case (r_state)
            stcd_pkg::S_IDLE: begin
                w_cmd.start    = w_accept;
                w_cmd.dividend = w_sat;
                w_cmd.divisor  = stcd_pkg::SEC_PER_DAY;
                w_cmd.nbits    = stcd_pkg::NBITS_DAY;
            end
            stcd_pkg::S_DIV_DAY: begin
                w_cmd.start    = w_stat.done;
                w_cmd.dividend = {w_rdays, {(stcd_pkg::DIV_W-stcd_pkg::DAYS_W){1'b0}}};
                w_cmd.divisor  = stcd_pkg::DAYS_PER_BLOCK;
                w_cmd.nbits    = stcd_pkg::NBITS_YEAR;
            end
            stcd_pkg::S_DIV_YEAR: begin
                w_cmd.start    = w_stat.done;
                w_cmd.dividend = {r_sod, {(stcd_pkg::DIV_W-stcd_pkg::SOD_W){1'b0}}};
                w_cmd.divisor  = stcd_pkg::SIXTY;
                w_cmd.nbits    = stcd_pkg::NBITS_MIN;
                w_walk_start   = w_stat.done;
            end
            stcd_pkg::S_DIV_MIN: begin
                w_cmd.start    = w_stat.done;
                w_cmd.dividend = {w_quo[stcd_pkg::MOD_W-1:0],
                                  {(stcd_pkg::DIV_W-stcd_pkg::MOD_W){1'b0}}};
                w_cmd.divisor  = stcd_pkg::SIXTY;
                w_cmd.nbits    = stcd_pkg::NBITS_HOUR;
            end
            stcd_pkg::S_DIV_HOUR, stcd_pkg::S_EMIT: begin
                w_cmd = '0;
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture results as divisions end; weekday folds during year division.
    always_ff @(posedge i_clk) begin
        if (r_state == stcd_pkg::S_DIV_DAY && w_stat.done) begin
            r_sod <= w_rem[stcd_pkg::SOD_W-1:0];
            r_wk  <= '0;
        end
        if (r_state == stcd_pkg::S_DIV_YEAR && w_stat.busy) begin
            r_wk <= n_wk;
        end
        if (r_state == stcd_pkg::S_DIV_MIN && w_stat.done) begin
            r_sec <= w_rem[stcd_pkg::SEC_W-1:0];
        end
        if (r_state == stcd_pkg::S_DIV_HOUR && w_stat.done) begin
            r_min  <= w_rem[stcd_pkg::MIN_W-1:0];
            r_hour <= w_quo[stcd_pkg::HOUR_W-1:0];
        end
    end

    // Output word register; the valid flag is the only control bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_year  <= w_walk.year;
            r_out_month <= w_walk.month;
            r_out_day   <= w_walk.day;
            r_out_hour  <= r_hour;
            r_out_min   <= r_min;
            r_out_sec   <= r_sec;
            r_out_wday  <= r_wk + 3'd1;
        end
    end

    assign i_in.ready         = (r_state == stcd_pkg::S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.year         = r_out_year;
    assign o_out.month        = r_out_month;
    assign o_out.day_of_month = r_out_day;
    assign o_out.hour         = r_out_hour;
    assign o_out.minute       = r_out_min;
    assign o_out.second       = r_out_sec;
    assign o_out.weekday      = r_out_wday;

endmodule

### rtl/stcd_serdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds to calendar date: bit-serial divider
// Restoring division, one quotient bit per cycle. The dividend is loaded
// left aligned and shifts out MSB first while quotient bits shift in.
// ----------------------------------------------------------------------------
module stcd_serdiv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stcd_pkg::t_div_cmd             i_cmd,
    output stcd_pkg::t_div_stat            o_stat,
    output logic [stcd_pkg::DIV_W-1:0]     o_quo,
    output logic [stcd_pkg::DVS_W-1:0]     o_rem
);

    logic [stcd_pkg::DIV_W-1:0] r_quo, n_quo;
    logic [stcd_pkg::DVS_W-1:0] r_rem, n_rem;
    logic [stcd_pkg::DVS_W-1:0] r_dvs;
    logic [stcd_pkg::CNT_W-1:0] r_cnt;
    logic                       r_done;

    logic                       w_bit;
    logic [stcd_pkg::DVS_W:0]   w_part;
    logic [stcd_pkg::DVS_W+1:0] w_diff;
    logic                       w_qbit;

    // One trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        w_bit  = r_quo[stcd_pkg::DIV_W-1];
        w_part = {r_rem, w_bit};
        w_diff = {1'b0, w_part} - {2'b00, r_dvs};
        w_qbit = ~w_diff[stcd_pkg::DVS_W+1];
        n_rem  = w_qbit ? w_diff[stcd_pkg::DVS_W-1:0] : w_part[stcd_pkg::DVS_W-1:0];
        n_quo  = {r_quo[stcd_pkg::DIV_W-2:0], w_qbit};
    end

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_cmd.start) begin
            r_cnt  <= i_cmd.nbits;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - {{(stcd_pkg::CNT_W-1){1'b0}}, 1'b1};
            r_done <= (r_cnt == {{(stcd_pkg::CNT_W-1){1'b0}}, 1'b1});
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo <= i_cmd.dividend;
            r_rem <= '0;
            r_dvs <= i_cmd.divisor;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy   = (r_cnt != '0);
    assign o_stat.done   = r_done;
    assign o_stat.bit_in = w_bit;
    assign o_quo         = r_quo;
    assign o_rem         = r_rem;

endmodule

### rtl/stcd_datewalk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds to calendar date: year and month walker
// From the four-year block count and the day within the block, steps through
// the years of the block and then through the months, one step per cycle.
// ----------------------------------------------------------------------------
module stcd_datewalk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [stcd_pkg::BLK_W-1:0]      i_blocks,
    input  logic [stcd_pkg::DOY_W-1:0]      i_day_in_block,
    output stcd_pkg::t_walk_res             o_res
);

    stcd_pkg::t_walk_state r_state, n_state;

    logic [stcd_pkg::YEAR_W-1:0]  r_base;
    logic [stcd_pkg::DOY_W-1:0]   r_rest;
    logic [1:0]                   r_yidx;
    logic [stcd_pkg::MONTH_W-1:0] r_month;

    logic                         w_leap;
    logic [stcd_pkg::DOY_W-1:0]   w_ylen;
    logic                         w_year_step;
    logic [stcd_pkg::DOY_W-1:0]   w_mlen;
    logic                         w_month_step;

    // Year and month step decisions. The first year of each block is a leap year.
    always_comb begin
        w_leap       = (r_yidx == 2'd0);
        w_ylen       = w_leap ? stcd_pkg::DAYS_LEAP_YEAR : stcd_pkg::DAYS_COMMON_YEAR;
        w_year_step  = (r_rest >= w_ylen) && (r_yidx != stcd_pkg::LAST_YEAR_IN_BLOCK);
        w_mlen       = {{(stcd_pkg::DOY_W-stcd_pkg::DAY_W){1'b0}},
                        stcd_pkg::month_len(r_month, w_leap)};
        w_month_step = (r_rest >= w_mlen) && (r_month != stcd_pkg::LAST_MONTH);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = stcd_pkg::W_YEAR;
        end else begin
            unique case (r_state)
                stcd_pkg::W_IDLE:  n_state = stcd_pkg::W_IDLE;
                stcd_pkg::W_YEAR:  if (!w_year_step) n_state = stcd_pkg::W_MONTH;
                stcd_pkg::W_MONTH: if (!w_month_step) n_state = stcd_pkg::W_DONE;
                stcd_pkg::W_DONE:  n_state = stcd_pkg::W_DONE;
                default:           n_state = stcd_pkg::W_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stcd_pkg::W_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers: remaining days, year within block, month.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_base  <= stcd_pkg::BASE_YEAR
                       + {{(stcd_pkg::YEAR_W-stcd_pkg::BLK_W-2){1'b0}}, i_blocks, 2'b00};
            r_rest  <= i_day_in_block;
            r_yidx  <= 2'd0;
            r_month <= '0;
        end else if (r_state == stcd_pkg::W_YEAR && w_year_step) begin
            r_rest <= r_rest - w_ylen;
            r_yidx <= r_yidx + 2'd1;
        end else if (r_state == stcd_pkg::W_MONTH && w_month_step) begin
            r_rest  <= r_rest - w_mlen;
            r_month <= r_month + {{(stcd_pkg::MONTH_W-1){1'b0}}, 1'b1};
        end
    end

    // Result outputs.
    always_comb begin
        o_res.done  = (r_state == stcd_pkg::W_DONE);
        o_res.year  = r_base + {{(stcd_pkg::YEAR_W-2){1'b0}}, r_yidx};
        o_res.month = r_month + {{(stcd_pkg::MONTH_W-1){1'b0}}, 1'b1};
        o_res.day   = r_rest[stcd_pkg::DAY_W-1:0] + {{(stcd_pkg::DAY_W-1){1'b0}}, 1'b1};
    end

endmodule

### rtl/stcd_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seconds to calendar date: port checker
// Watches the conversion unit's ports for output ranges, busy behavior
// after an accepted word, reset behavior and a stable stalled output.
// ----------------------------------------------------------------------------
module stcd_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [stcd_pkg::YEAR_W-1:0]     i_year,
    input  logic [stcd_pkg::MONTH_W-1:0]    i_month,
    input  logic [stcd_pkg::DAY_W-1:0]      i_day,
    input  logic [stcd_pkg::HOUR_W-1:0]     i_hour,
    input  logic [stcd_pkg::MIN_W-1:0]      i_minute,
    input  logic [stcd_pkg::SEC_W-1:0]      i_second,
    input  logic [stcd_pkg::WDAY_W-1:0]     i_weekday
);

    // Every delivered word has each field within its calendar range for the supported span.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_year >= 12'd1970) && (i_year <= 12'd2099)
                     && (i_month >= 4'd1) && (i_month <= 4'd12)
                     && (i_day >= 5'd1) && (i_day <= 5'd31)
                     && (i_hour <= 5'd23) && (i_minute <= 6'd59)
                     && (i_second <= 6'd59)
                     && (i_weekday >= 3'd1) && (i_weekday <= 3'd7))
        else $error("output word out of calendar range");

    // One word at a time: the unit is busy right after an accepted word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted again while a conversion is running");

    // Reset leaves the unit ready and with no output pending.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("unit not idle after reset");

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_year)
            && $stable(i_month) && $stable(i_day) && $stable(i_hour)
            && $stable(i_minute) && $stable(i_second) && $stable(i_weekday))
        else $error("stalled output word changed");

endmodule

bind seconds_to_calendar_date_unit stcd_chk u_stcd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_year      (o_out.year),
    .i_month     (o_out.month),
    .i_day       (o_out.day_of_month),
    .i_hour      (o_out.hour),
    .i_minute    (o_out.minute),
    .i_second    (o_out.second),
    .i_weekday   (o_out.weekday)
);
